>>> src/hba_pkg.sv
package hba_pkg;

   localparam int NUM_BINS_DEFAULT = 256;
   localparam logic [8:0] BINS_IN_USE_RESET = 9'd256;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_READ  = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_MISS  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_WRITE,
      OP_ADD,
      OP_READ,
      OP_RANGE,
      OP_MISS
   } op_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_EDGE,
      B_PROBE,
      B_ACC,
      B_OUT
   } back_state_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  bin;
      logic [31:0] low_edge;
      logic [31:0] high_edge;
      logic [31:0] key;
      logic [47:0] triangles;
      logic [15:0] base_degree;
      logic [31:0] remainder;
   } q_entry_type;

   typedef struct packed {
      logic [39:0] count;
      logic [63:0] tri_sum;
      logic [47:0] deg_sum;
      logic [47:0] rem_sum;
   } acc_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  hit_bin;
      acc_type     acc;
   } result_type;

endpackage

>>> src/hba_ifs.sv
interface hba_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [7:0]  bin_index;
   logic [31:0] low_edge_in;
   logic [31:0] high_edge_in;
   logic [31:0] total_degree;
   logic [47:0] triangles;
   logic [15:0] base_degree;

   modport source (output valid, command, bin_index, low_edge_in, high_edge_in,
                   total_degree, triangles, base_degree, input ready);
   modport sink (input valid, command, bin_index, low_edge_in, high_edge_in,
                 total_degree, triangles, base_degree, output ready);
endinterface

interface hba_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  hit_bin;
   logic [39:0] hit_count;
   logic [63:0] triangle_total;
   logic [47:0] degree_total;
   logic [47:0] remainder_total;

   modport source (output valid, status, hit_bin, hit_count, triangle_total,
                   degree_total, remainder_total, input ready);
   modport sink (input valid, status, hit_bin, hit_count, triangle_total,
                 degree_total, remainder_total, output ready);
endinterface

interface hba_csr_if;
   logic       valid;
   logic       ready;
   logic [8:0] bins_in_use;

   modport source (output valid, bins_in_use, input ready);
   modport sink (input valid, bins_in_use, output ready);
endinterface

>>> src/hba_ram.sv
module hba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> src/hba_fifo.sv
module hba_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  hba_pkg::q_entry_type push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output hba_pkg::q_entry_type head
);
   import hba_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   q_entry_type      mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   assign full = (cnt_ff == CW'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end
endmodule

>>> src/hba_front.sv
module hba_front #(
   parameter int NUM_BINS = hba_pkg::NUM_BINS_DEFAULT
) (
   hba_req_if.sink                        req_chan,
   input  logic [$clog2(NUM_BINS+1)-1:0]  n_bins,
   input  logic                           clearing,
   input  logic                           queue_full,
   output logic                           push,
   output hba_pkg::q_entry_type           push_data
);
   import hba_pkg::*;

   localparam int NW = $clog2(NUM_BINS + 1);
   localparam int KW = (NW > 8) ? NW : 8;

   logic index_bad;

   assign req_chan.ready = !queue_full && !clearing;
   assign push = req_chan.valid && req_chan.ready;
   assign index_bad = (KW'(req_chan.bin_index) >= KW'(n_bins));

   always_comb begin
      push_data.bin = req_chan.bin_index;
      push_data.low_edge = req_chan.low_edge_in;
      push_data.high_edge = req_chan.high_edge_in;
      push_data.key = req_chan.total_degree;
      push_data.triangles = req_chan.triangles;
      push_data.base_degree = req_chan.base_degree;
      push_data.remainder = (req_chan.total_degree > 32'(req_chan.base_degree)) ?
                            req_chan.total_degree - 32'(req_chan.base_degree) : '0;
      if (req_chan.command == CMD_ADD) begin
         push_data.op = (n_bins == '0) ? OP_MISS : OP_ADD;
      end else if (index_bad) begin
         push_data.op = OP_RANGE;
      end else if (req_chan.command == CMD_WRITE) begin
         push_data.op = OP_WRITE;
      end else begin
         push_data.op = OP_READ;
      end
   end
endmodule

>>> src/hba_back.sv
module hba_back #(
   parameter int NUM_BINS = hba_pkg::NUM_BINS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [$clog2(NUM_BINS+1)-1:0]  n_bins,
   input  logic                           q_valid,
   input  hba_pkg::q_entry_type           q_head,
   output logic                           pop,
   output logic                           clearing,
   hba_rsp_if.source                      rsp_chan
);
   import hba_pkg::*;

   localparam int NW = $clog2(NUM_BINS + 1);
   localparam int IW = $clog2(NUM_BINS);

   back_state_type state_ff, state_in;
   q_entry_type    ent_ff, ent_in;
   logic [NW-1:0]  lo_ff, lo_in, hend_ff, hend_in, mid_ff, mid_in;
   logic [IW-1:0]  bin_ff, bin_in, clr_ff, clr_in;
   result_type     res_ff, res_in, rsp_data_ff, rsp_data_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic           edge_we;
   logic [IW-1:0]  edge_waddr, low_raddr, high_raddr;
   logic [31:0]    low_rd, high_rd;
   logic           acc_we;
   logic [IW-1:0]  acc_waddr, acc_raddr;
   acc_type        acc_wdata, acc_rd, acc_new;

   logic [NW:0]    mid_sum;
   logic [NW-1:0]  probe_lo, probe_hend;
   logic           key_below, key_above;
   logic           c_cnt, c_tri, c_deg, c_rem;
   logic [39:0]    s_cnt;
   logic [63:0]    s_tri;
   logic [47:0]    s_deg, s_rem;

   hba_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_low_ram (
      .clock(clock), .we(edge_we), .waddr(edge_waddr), .wdata(ent_in.low_edge),
      .raddr(low_raddr), .rdata(low_rd));

   hba_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_high_ram (
      .clock(clock), .we(edge_we), .waddr(edge_waddr), .wdata(ent_in.high_edge),
      .raddr(high_raddr), .rdata(high_rd));

   hba_ram #(.WIDTH($bits(acc_type)), .DEPTH(NUM_BINS)) u_acc_ram (
      .clock(clock), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
      .raddr(acc_raddr), .rdata(acc_rd));

   assign clearing = (state_ff == B_CLEAR);
   assign key_below = (ent_ff.key < low_rd);
   assign key_above = (ent_ff.key > high_rd);

   assign {c_cnt, s_cnt} = 41'(acc_rd.count) + 41'd1;
   assign {c_tri, s_tri} = 65'(acc_rd.tri_sum) + 65'(ent_ff.triangles);
   assign {c_deg, s_deg} = 49'(acc_rd.deg_sum) + 49'(ent_ff.base_degree);
   assign {c_rem, s_rem} = 49'(acc_rd.rem_sum) + 49'(ent_ff.remainder);

   always_comb begin
      acc_new.count = c_cnt ? '1 : s_cnt;
      acc_new.tri_sum = c_tri ? '1 : s_tri;
      acc_new.deg_sum = c_deg ? '1 : s_deg;
      acc_new.rem_sum = c_rem ? '1 : s_rem;
   end

   always_comb begin
      if (key_below) begin
         probe_lo = lo_ff;
         probe_hend = mid_ff;
      end else begin
         probe_lo = mid_ff + 1'b1;
         probe_hend = hend_ff;
      end
      if (state_ff == B_EDGE) begin
         mid_sum = (NW + 1)'(n_bins) - 1'b1;
      end else begin
         mid_sum = (NW + 1)'(probe_lo) + (NW + 1)'(probe_hend) - 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      ent_in = ent_ff;
      lo_in = lo_ff;
      hend_in = hend_ff;
      mid_in = mid_ff;
      bin_in = bin_ff;
      clr_in = clr_ff;
      res_in = res_ff;
      pop = 1'b0;
      edge_we = 1'b0;
      edge_waddr = bin_ff;
      low_raddr = IW'(mid_sum >> 1);
      high_raddr = IW'(mid_sum >> 1);
      acc_we = 1'b0;
      acc_waddr = bin_ff;
      acc_wdata = '0;
      acc_raddr = bin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in = rsp_data_ff;

      unique case (state_ff)
         B_CLEAR: begin
            acc_we = 1'b1;
            acc_waddr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IW'(NUM_BINS - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (q_valid) begin
               pop = 1'b1;
               ent_in = q_head;
               bin_in = IW'(q_head.bin);
               res_in = '0;
               res_in.status = STAT_OK;
               res_in.hit_bin = q_head.bin;
               unique case (q_head.op)
                  OP_WRITE: begin
                     edge_we = 1'b1;
                     edge_waddr = IW'(q_head.bin);
                     acc_we = 1'b1;
                     acc_waddr = IW'(q_head.bin);
                     state_in = B_OUT;
                  end
                  OP_READ: begin
                     acc_raddr = IW'(q_head.bin);
                     state_in = B_ACC;
                  end
                  OP_ADD: begin
                     low_raddr = '0;
                     high_raddr = IW'(n_bins - 1'b1);
                     state_in = B_EDGE;
                  end
                  OP_RANGE: begin
                     res_in.status = STAT_RANGE;
                     res_in.hit_bin = '0;
                     state_in = B_OUT;
                  end
                  default: begin
                     res_in.status = STAT_MISS;
                     res_in.hit_bin = '0;
                     state_in = B_OUT;
                  end
               endcase
            end
         end
         B_EDGE: begin
            if (key_below || key_above) begin
               res_in.status = STAT_MISS;
               res_in.hit_bin = '0;
               state_in = B_OUT;
            end else begin
               lo_in = '0;
               hend_in = n_bins;
               mid_in = NW'(mid_sum >> 1);
               state_in = B_PROBE;
            end
         end
         B_PROBE: begin
            if (!key_below && !key_above) begin
               bin_in = IW'(mid_ff);
               acc_raddr = IW'(mid_ff);
               state_in = B_ACC;
            end else if (probe_lo >= probe_hend) begin
               res_in.status = STAT_MISS;
               res_in.hit_bin = '0;
               state_in = B_OUT;
            end else begin
               lo_in = probe_lo;
               hend_in = probe_hend;
               mid_in = NW'(mid_sum >> 1);
            end
         end
         B_ACC: begin
            res_in.status = STAT_OK;
            res_in.hit_bin = 8'(bin_ff);
            if (ent_ff.op == OP_ADD) begin
               acc_we = 1'b1;
               acc_wdata = acc_new;
               res_in.acc = acc_new;
            end else begin
               res_in.acc = acc_rd;
            end
            state_in = B_OUT;
         end
         B_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_ff;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ent_ff <= ent_in;
      lo_ff <= lo_in;
      hend_ff <= hend_in;
      mid_ff <= mid_in;
      bin_ff <= bin_in;
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_data_ff.status;
   assign rsp_chan.hit_bin = rsp_data_ff.hit_bin;
   assign rsp_chan.hit_count = rsp_data_ff.acc.count;
   assign rsp_chan.triangle_total = rsp_data_ff.acc.tri_sum;
   assign rsp_chan.degree_total = rsp_data_ff.acc.deg_sum;
   assign rsp_chan.remainder_total = rsp_data_ff.acc.rem_sum;
endmodule

>>> src/binned_histogram_accumulator.sv
// Histogram engine with variable-width bins and saturating accumulators.
// Requests enter on req_chan: write bin edges (clears the bin), add a sample,
// or read a bin. Each request yields exactly one response on rsp_chan, in order.
// csr_chan writes bins_in_use; it is always ready and must only be written
// while no request is outstanding.
// A front stage classifies each request and places it in a two-entry queue;
// a back sequencer executes it against three single-port-read RAMs.
// Back-end states per request: write IDLE, OUT; read IDLE, ACC, OUT; add IDLE,
// EDGE, one PROBE per binary-search probe (at most floor(log2(bins))+1 probes),
// ACC, OUT; the probe loop is bound by the registered read of the edge RAMs.
// An accepted request is registered in the queue before the back end takes it.
// After reset the back end zeroes the accumulator RAM, one bin per cycle,
// through all NUM_BINS bins; req_chan.ready stays low until that pass ends.
// When the receiver stalls, the response holds in its output register, the
// back end waits, and the queue keeps accepting until it is full.
module binned_histogram_accumulator #(
   parameter int NUM_BINS = hba_pkg::NUM_BINS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   hba_csr_if.sink     csr_chan,
   hba_req_if.sink     req_chan,
   hba_rsp_if.source   rsp_chan
);
   import hba_pkg::*;

   localparam int NW = $clog2(NUM_BINS + 1);
   localparam int CW = (NW > 9) ? NW : 9;

   logic [8:0]    biu_ff, biu_in;
   logic [NW-1:0] n_bins;
   logic          clearing, queue_full, push, pop, q_valid;
   q_entry_type   push_data, q_head;

   assign csr_chan.ready = 1'b1;
   assign biu_in = (csr_chan.valid) ? csr_chan.bins_in_use : biu_ff;
   assign n_bins = (CW'(biu_ff) > CW'(NUM_BINS)) ? NW'(NUM_BINS) : NW'(biu_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         biu_ff <= BINS_IN_USE_RESET;
      end else begin
         biu_ff <= biu_in;
      end
   end

   hba_front #(.NUM_BINS(NUM_BINS)) u_front (
      .req_chan(req_chan), .n_bins(n_bins), .clearing(clearing),
      .queue_full(queue_full), .push(push), .push_data(push_data));

   hba_fifo u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data),
      .pop(pop), .full(queue_full), .not_empty(q_valid), .head(q_head));

   hba_back #(.NUM_BINS(NUM_BINS)) u_back (
      .clock(clock), .reset(reset), .n_bins(n_bins), .q_valid(q_valid),
      .q_head(q_head), .pop(pop), .clearing(clearing), .rsp_chan(rsp_chan));
endmodule

>>> tb/binned_histogram_accumulator_tb.sv
`timescale 1ns / 100ps

module binned_histogram_accumulator_tb;
   import hba_pkg::*;

   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam int BIN_PITCH = 1000;
   localparam int BIN_SPAN = 800;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic [1:0]  command;
      logic [7:0]  bin_index;
      logic [31:0] low_edge;
      logic [31:0] high_edge;
      logic [31:0] key;
      logic [47:0] triangles;
      logic [15:0] base_degree;
   } request_type;

   typedef struct {
      logic [1:0]  status;
      logic [7:0]  hit_bin;
      logic [39:0] count;
      logic [63:0] tri_sum;
      logic [47:0] deg_sum;
      logic [47:0] rem_sum;
   } bin_report_type;

   class histogram_scoreboard;
      logic [31:0] low_edge[256];
      logic [31:0] high_edge[256];
      logic [39:0] count[256];
      logic [63:0] tri_sum[256];
      logic [47:0] deg_sum[256];
      logic [47:0] rem_sum[256];
      logic [8:0]  bins_in_use;
      bin_report_type expected_reports[$];
      int errors;

      function new();
         bins_in_use = BINS_IN_USE_RESET;
         errors = 0;
         foreach (count[i]) begin
            low_edge[i] = '0;
            high_edge[i] = '0;
            count[i] = '0;
            tri_sum[i] = '0;
            deg_sum[i] = '0;
            rem_sum[i] = '0;
         end
      endfunction

      function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] max);
         if (a > max) a = max;
         if (b >= max - a) return max;
         return a + b;
      endfunction

      function bin_report_type bin_report(int b);
         bin_report_type r;
         r.status = STAT_OK;
         r.hit_bin = b[7:0];
         r.count = count[b];
         r.tri_sum = tri_sum[b];
         r.deg_sum = deg_sum[b];
         r.rem_sum = rem_sum[b];
         return r;
      endfunction

      function void note_request(request_type q);
         bin_report_type r;
         int n, lo, hi, mid, b;
         logic [47:0] rem;
         logic [64:0] wide;
         n = (bins_in_use > 256) ? 256 : bins_in_use;
         r = '{STAT_OK, 8'd0, 40'd0, 64'd0, 48'd0, 48'd0};
         if (q.command == CMD_ADD) begin
            rem = (q.key > q.base_degree) ? q.key - q.base_degree : '0;
            b = -1;
            if (n > 0 && q.key >= low_edge[0] && q.key <= high_edge[n - 1]) begin
               lo = 0;
               hi = n - 1;
               while (lo <= hi && b < 0) begin
                  mid = (lo + hi) / 2;
                  if (q.key < low_edge[mid]) hi = mid - 1;
                  else if (q.key > high_edge[mid]) lo = mid + 1;
                  else b = mid;
               end
            end
            if (b < 0) begin
               r.status = STAT_MISS;
            end else begin
               count[b] = 40'(sat_add(count[b], 1, 64'hFF_FFFF_FFFF));
               wide = {1'b0, tri_sum[b]} + q.triangles;
               tri_sum[b] = wide[64] ? '1 : wide[63:0];
               deg_sum[b] = 48'(sat_add(deg_sum[b], q.base_degree, 64'hFFFF_FFFF_FFFF));
               rem_sum[b] = 48'(sat_add(rem_sum[b], rem, 64'hFFFF_FFFF_FFFF));
               r = bin_report(b);
            end
         end else if (q.bin_index >= n) begin
            r.status = STAT_RANGE;
         end else begin
            if (q.command == CMD_WRITE) begin
               low_edge[q.bin_index] = q.low_edge;
               high_edge[q.bin_index] = q.high_edge;
               count[q.bin_index] = '0;
               tri_sum[q.bin_index] = '0;
               deg_sum[q.bin_index] = '0;
               rem_sum[q.bin_index] = '0;
            end
            r = bin_report(q.bin_index);
         end
         expected_reports.push_back(r);
      endfunction

      function void check_response(bin_report_type got);
         bin_report_type exp;
         if (expected_reports.size() == 0) begin
            $display("%0t: response with none expected, status %0d bin %0d", $time,
                     got.status, got.hit_bin);
            errors++;
            return;
         end
         exp = expected_reports.pop_front();
         if (got.status !== exp.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
            errors++;
         end
         if (got.hit_bin !== exp.hit_bin) begin
            $display("%0t: hit_bin expected %0d actual %0d", $time, exp.hit_bin, got.hit_bin);
            errors++;
         end
         if (got.count !== exp.count) begin
            $display("%0t: hit_count expected %h actual %h", $time, exp.count, got.count);
            errors++;
         end
         if (got.tri_sum !== exp.tri_sum) begin
            $display("%0t: triangle_total expected %h actual %h", $time, exp.tri_sum,
                     got.tri_sum);
            errors++;
         end
         if (got.deg_sum !== exp.deg_sum) begin
            $display("%0t: degree_total expected %h actual %h", $time, exp.deg_sum,
                     got.deg_sum);
            errors++;
         end
         if (got.rem_sum !== exp.rem_sum) begin
            $display("%0t: remainder_total expected %h actual %h", $time, exp.rem_sum,
                     got.rem_sum);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int send_idle_pct;
   int recv_stall_pct;
   bit hold_request;
   int hold_left;
   int cycles;
   histogram_scoreboard scoreboard;

   hba_req_if req_chan();
   hba_rsp_if rsp_chan();
   hba_csr_if csr_chan();

   binned_histogram_accumulator dut (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan.sink),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_chan.valid && csr_chan.ready) scoreboard.bins_in_use = csr_chan.bins_in_use;
         if (req_chan.valid && req_chan.ready)
            scoreboard.note_request('{req_chan.command, req_chan.bin_index,
               req_chan.low_edge_in, req_chan.high_edge_in, req_chan.total_degree,
               req_chan.triangles, req_chan.base_degree});
         if (rsp_chan.valid && rsp_chan.ready)
            scoreboard.check_response('{rsp_chan.status, rsp_chan.hit_bin,
               rsp_chan.hit_count, rsp_chan.triangle_total, rsp_chan.degree_total,
               rsp_chan.remainder_total});
      end
   end

   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready = 1'b0;
      end else begin
         rsp_chan.ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_request(request_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.command = q.command;
      req_chan.bin_index = q.bin_index;
      req_chan.low_edge_in = q.low_edge;
      req_chan.high_edge_in = q.high_edge;
      req_chan.total_degree = q.key;
      req_chan.triangles = q.triangles;
      req_chan.base_degree = q.base_degree;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   task automatic write_bins_in_use(logic [8:0] value);
      csr_chan.valid = 1'b1;
      csr_chan.bins_in_use = value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (scoreboard.expected_reports.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic request_type bin_write(int b);
      request_type q;
      q = '{CMD_WRITE, b[7:0], 32'(b * BIN_PITCH), 32'(b * BIN_PITCH + BIN_SPAN - 1),
            $urandom, 48'({$urandom, $urandom}), 16'($urandom)};
      if (b == 255) q.high_edge = '1;
      return q;
   endfunction

   function automatic request_type random_request();
      request_type q;
      int pick, b;
      pick = $urandom_range(99);
      b = $urandom_range(255);
      q = '{CMD_ADD, 8'($urandom), $urandom, $urandom, $urandom,
            48'({$urandom, $urandom}), 16'($urandom)};
      if (pick < 60) begin
         q.key = 32'(b * BIN_PITCH) + $urandom_range(BIN_PITCH - 1);
         if ($urandom_range(3) == 0) q.base_degree = 16'($urandom_range(q.key + 200));
      end else if (pick < 68) begin
         q.command = CMD_ADD;
      end else if (pick < 80) begin
         q = bin_write(q.bin_index);
      end else if (pick < 85) begin
         q.command = CMD_WRITE;
      end else begin
         q.command = ($urandom_range(3) == 0) ? CMD_SPARE : CMD_READ;
      end
      return q;
   endfunction

   initial begin
      request_type q;
      logic [8:0] settings[6];
      scoreboard = new();
      settings = '{9'd256, 9'd0, 9'd1, 9'd511, 9'd37, 9'd256};
      reset = 1'b1;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 1'b0;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.command = CMD_READ;
      req_chan.bin_index = '0;
      req_chan.low_edge_in = '0;
      req_chan.high_edge_in = '0;
      req_chan.total_degree = '0;
      req_chan.triangles = '0;
      req_chan.base_degree = '0;
      csr_chan.valid = 1'b0;
      csr_chan.bins_in_use = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int b = 0; b < 256; b++) send_request(bin_write(b));

      send_request('{CMD_ADD, 8'd0, 32'd0, 32'd0, 32'd0, '1, 16'hFFFF});
      send_request('{CMD_ADD, 8'd0, 32'd0, 32'd0, '1, '1, 16'hFFFF});
      send_request('{CMD_ADD, 8'd0, 32'd0, 32'd0, 32'd800, 48'd1, 16'd0});
      send_request('{CMD_ADD, 8'd0, 32'd0, 32'd0, 32'd5000, 48'h10000, 16'd60000});
      send_request('{CMD_ADD, 8'd0, 32'd0, 32'd0, 32'd5001, '0, 16'd1});
      send_request('{CMD_READ, 8'd5, 32'd0, 32'd0, 32'd0, '0, 16'd0});
      send_request('{CMD_SPARE, 8'd255, 32'd0, 32'd0, 32'd0, '0, 16'd0});
      send_request('{CMD_WRITE, 8'd10, 32'd10799, 32'd10000, '1, '1, '1});
      send_request('{CMD_ADD, 8'd0, 32'd0, 32'd0, 32'd10500, '1, 16'd3});
      send_request('{CMD_WRITE, 8'd11, 32'd9000, 32'd12500, '0, '0, '0});
      send_request('{CMD_ADD, 8'd0, 32'd0, 32'd0, 32'd12100, 48'd7, 16'd9});
      send_request('{CMD_READ, 8'd11, 32'd0, 32'd0, 32'd0, '0, 16'd0});
      send_request(bin_write(10));
      send_request(bin_write(11));

      foreach (settings[s]) begin
         wait_drained();
         write_bins_in_use(settings[s]);
         for (int mode = 0; mode < 4; mode++) begin
            send_idle_pct = (mode == 1) ? 67 : (mode == 3) ? 34 : 0;
            recv_stall_pct = (mode == 2) ? 67 : (mode == 3) ? 34 : 0;
            if (s == 0 && mode == 0) begin
               @(posedge clock);
               hold_request = 1'b1;
               @(posedge clock);
               hold_request = 1'b0;
               @(negedge clock);
            end
            for (int i = 0; i < 70; i++) begin
               q = random_request();
               send_request(q);
            end
         end
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait_drained();
      if (scoreboard.errors == 0 && scoreboard.expected_reports.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
src/hba_pkg.sv
src/hba_ifs.sv
src/hba_ram.sv
src/hba_fifo.sv
src/hba_front.sv
src/hba_back.sv
src/binned_histogram_accumulator.sv
tb/binned_histogram_accumulator_tb.sv
